// File: hw/rtl/wsps_pkg.sv
// Shared types and constants for the WS2812 pulse-width serializer.
`default_nettype none

package wsps_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_GAP   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int TIME_BITS      = 10;
    localparam int LATCH_BITS     = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ONE_HIGH   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LATCH      = 2'd3;

    localparam logic [TIME_BITS-1:0]  RST_BIT_PERIOD = 10'd60;
    localparam logic [TIME_BITS-1:0]  RST_ZERO_HIGH  = 10'd17;
    localparam logic [TIME_BITS-1:0]  RST_ONE_HIGH   = 10'd34;
    localparam logic [LATCH_BITS-1:0] RST_LATCH      = 16'd48000;

    typedef struct packed {
        logic [TIME_BITS-1:0]  bit_period_ticks;
        logic [TIME_BITS-1:0]  zero_high_ticks;
        logic [TIME_BITS-1:0]  one_high_ticks;
        logic [LATCH_BITS-1:0] latch_ticks;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic byte_taken;
        logic busy_res;
        logic underrun;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/wsps_cfg_regs.sv
// Configuration register file of the serializer.
`default_nettype none

module wsps_cfg_regs
    import wsps_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BIT_PERIOD: cfg_next.bit_period_ticks = cfg_data[TIME_BITS-1:0];
                REG_ZERO_HIGH:  cfg_next.zero_high_ticks  = cfg_data[TIME_BITS-1:0];
                REG_ONE_HIGH:   cfg_next.one_high_ticks   = cfg_data[TIME_BITS-1:0];
                REG_LATCH:      cfg_next.latch_ticks      = cfg_data[LATCH_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_period_ticks <= RST_BIT_PERIOD;
            cfg_reg.zero_high_ticks  <= RST_ZERO_HIGH;
            cfg_reg.one_high_ticks   <= RST_ONE_HIGH;
            cfg_reg.latch_ticks      <= RST_LATCH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wsps_encoder.sv
// Bit timing state machine: one tick of the line waveform per request.
`default_nettype none

module wsps_encoder
    import wsps_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic       byte_valid,
    input  wire logic [7:0] byte_value,
    input  wire logic       byte_last,
    input  wire cfg_t       cfg,
    output result_t         result
);

    localparam int CMP_BITS = (COUNT_BITS > LATCH_BITS) ? COUNT_BITS : LATCH_BITS;

    phase_t                phase_reg, phase_next;
    logic [7:0]            shift_reg, shift_next;
    logic [2:0]            index_reg, index_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  final_reg, final_next;

    phase_t                ph0;
    logic [7:0]            sb0;
    logic [2:0]            bi0;
    logic [COUNT_BITS-1:0] tc0;
    logic                  fp0;
    logic                  take;
    logic [TIME_BITS-1:0]  high_ticks;
    logic [TIME_BITS-1:0]  period_eff;
    logic [COUNT_BITS:0]   tc_inc;
    logic [COUNT_BITS-1:0] tc_wrap;
    logic [CMP_BITS-1:0]   latch_w;
    logic [CMP_BITS-1:0]   mask_w;
    logic [CMP_BITS-1:0]   latch_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            index_reg <= '0;
            count_reg <= '0;
            final_reg <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            index_reg <= index_next;
            count_reg <= count_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        take = ((phase_reg == PH_IDLE) || (phase_reg == PH_GAP)) && byte_valid;
        ph0  = take ? PH_SEND : phase_reg;
        sb0  = take ? byte_value : shift_reg;
        bi0  = take ? 3'd0 : index_reg;
        tc0  = take ? '0 : count_reg;
        fp0  = take ? byte_last : final_reg;

        high_ticks = sb0[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
        period_eff = (cfg.bit_period_ticks == '0) ? TIME_BITS'(1) : cfg.bit_period_ticks;
        tc_inc     = {1'b0, tc0} + (COUNT_BITS+1)'(1);
        tc_wrap    = tc_inc[COUNT_BITS-1:0];
        latch_w    = CMP_BITS'(cfg.latch_ticks);
        mask_w     = CMP_BITS'({COUNT_BITS{1'b1}});
        latch_eff  = (latch_w > mask_w) ? mask_w : latch_w;

        phase_next = ph0;
        shift_next = sb0;
        index_next = bi0;
        count_next = tc0;
        final_next = fp0;
        result     = '0;
        result.byte_taken = take;

        unique case (ph0)
            PH_SEND: begin
                result.busy_res   = 1'b1;
                result.line_level = tc0 < COUNT_BITS'(high_ticks);
                if (tc_inc >= (COUNT_BITS+1)'(period_eff)) begin
                    count_next = '0;
                    shift_next = {sb0[6:0], 1'b0};
                    if (bi0 == 3'd7) begin
                        index_next = 3'd0;
                        if (fp0) begin
                            final_next = 1'b0;
                            phase_next = (latch_eff == '0) ? PH_IDLE : PH_LATCH;
                        end else begin
                            phase_next = PH_GAP;
                        end
                    end else begin
                        index_next = bi0 + 3'd1;
                    end
                end else begin
                    count_next = tc_wrap;
                end
            end
            PH_GAP: begin
                result.busy_res = 1'b1;
                result.underrun = 1'b1;
            end
            PH_LATCH: begin
                result.busy_res = 1'b1;
                if ((CMP_BITS'(tc_wrap) >= latch_eff) || (tc_wrap == '0)) begin
                    count_next = '0;
                    phase_next = PH_IDLE;
                end else begin
                    count_next = tc_wrap;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/ws2812_pulse_width_serializer_top.sv
// Top level of the WS2812 pulse-width serializer.
// Each request on the s_ channel is one tick of the LED line waveform and
// may offer a byte (s_byte_valid) with its end-of-frame mark (s_byte_last).
// Each request yields exactly one result on the m_ channel: the line level
// for that tick, whether the offered byte was taken, busy and underrun.
// Bytes go out MSB first; each bit lasts bit_period_ticks, high for the
// one or zero high time, then low. After the last byte the line stays low
// for latch_ticks before the block goes idle.
// A request is registered at the input, worked through the bit timing
// state machine and held in the output register: m_valid rises once the
// result is registered; one request per cycle while m_ready stays high.
// When m_ready is low the output register holds and the input register
// takes one more request, then s_ready drops until the result is taken.
// The cfg_ channel writes the four timing registers, always ready; writes
// must be made only while no request is in flight; the block never checks it.
// Synchronous reset (aresetn low) empties both registers, returns the
// state machine to idle and loads the default timing (60/17/34/48000).
`default_nettype none

module ws2812_pulse_width_serializer_top
    import wsps_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_byte_valid,
    input  wire logic [7:0]                s_byte_value,
    input  wire logic                      s_byte_last,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_line_level,
    output logic                           m_byte_taken,
    output logic                           m_busy_res,
    output logic                           m_underrun,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t       cfg;
    result_t    result;
    result_t    out_reg;
    logic       in_valid_reg;
    logic       in_bv_reg;
    logic [7:0] in_value_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_bv_reg    <= s_byte_valid;
            in_value_reg <= s_byte_value;
            in_last_reg  <= s_byte_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    wsps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wsps_encoder #(
        .COUNT_BITS (COUNT_BITS)
    ) u_encoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .byte_valid (in_bv_reg),
        .byte_value (in_value_reg),
        .byte_last  (in_last_reg),
        .cfg        (cfg),
        .result     (result)
    );

    assign m_valid      = out_valid_reg;
    assign m_line_level = out_reg.line_level;
    assign m_byte_taken = out_reg.byte_taken;
    assign m_busy_res   = out_reg.busy_res;
    assign m_underrun   = out_reg.underrun;

endmodule

`default_nettype wire

// File: tb/ws2812_pulse_width_serializer_top_tb.sv
// Self-checking testbench for the WS2812 pulse-width serializer top level.
`default_nettype none

module ws2812_pulse_width_serializer_top_tb;
    import wsps_pkg::*;

    localparam int unsigned CNT_MAX = 32'h0000_FFFF;

    // Tick-by-tick model of the line encoder and the queue of expected results.
    class line_tick_scoreboard;
        logic [TIME_BITS-1:0]  period_r;
        logic [TIME_BITS-1:0]  zero_hi_r;
        logic [TIME_BITS-1:0]  one_hi_r;
        logic [LATCH_BITS-1:0] latch_r;
        phase_t                ph;
        logic [7:0]            shreg;
        logic [2:0]            bit_no;
        int unsigned           cnt;
        bit                    final_pend;
        result_t               expected_ticks[$];
        int                    errors;

        function new();
            period_r   = RST_BIT_PERIOD;
            zero_hi_r  = RST_ZERO_HIGH;
            one_hi_r   = RST_ONE_HIGH;
            latch_r    = RST_LATCH;
            ph         = PH_IDLE;
            shreg      = '0;
            bit_no     = '0;
            cnt        = 0;
            final_pend = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_BIT_PERIOD: period_r  = data[TIME_BITS-1:0];
                REG_ZERO_HIGH:  zero_hi_r = data[TIME_BITS-1:0];
                REG_ONE_HIGH:   one_hi_r  = data[TIME_BITS-1:0];
                REG_LATCH:      latch_r   = data[LATCH_BITS-1:0];
                default: ;
            endcase
        endfunction

        function phase_t phase_now();
            return ph;
        endfunction

        function int outstanding();
            return expected_ticks.size();
        endfunction

        function void note_request(bit bv, logic [7:0] val, bit last);
            result_t     r;
            int unsigned per;
            int unsigned hi;
            r   = '0;
            per = (period_r == 0) ? 1 : int'(period_r);
            if ((ph == PH_IDLE || ph == PH_GAP) && bv) begin
                shreg        = val;
                bit_no       = '0;
                cnt          = 0;
                final_pend   = last;
                ph           = PH_SEND;
                r.byte_taken = 1'b1;
            end
            case (ph)
                PH_SEND: begin
                    hi           = shreg[7] ? int'(one_hi_r) : int'(zero_hi_r);
                    r.line_level = (cnt < hi);
                    r.busy_res   = 1'b1;
                    if (cnt + 1 >= per) begin
                        cnt   = 0;
                        shreg = shreg << 1;
                        if (bit_no == 3'd7) begin
                            bit_no = '0;
                            if (final_pend) begin
                                final_pend = 0;
                                ph = (latch_r == 0) ? PH_IDLE : PH_LATCH;
                            end else begin
                                ph = PH_GAP;
                            end
                        end else begin
                            bit_no = bit_no + 3'd1;
                        end
                    end else begin
                        cnt = (cnt + 1) & CNT_MAX;
                    end
                end
                PH_GAP: begin
                    r.busy_res = 1'b1;
                    r.underrun = 1'b1;
                end
                PH_LATCH: begin
                    r.busy_res = 1'b1;
                    cnt = (cnt + 1) & CNT_MAX;
                    if (cnt >= int'(latch_r) || cnt == 0) begin
                        cnt = 0;
                        ph  = PH_IDLE;
                    end
                end
                default: ;
            endcase
            expected_ticks.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (expected_ticks.size() == 0) begin
                $error("result with no request outstanding: level %0d taken %0d busy %0d under %0d",
                       got.line_level, got.byte_taken, got.busy_res, got.underrun);
                errors++;
                return;
            end
            e = expected_ticks.pop_front();
            if (got.line_level !== e.line_level) begin
                $error("line_level: expected %0d, actual %0d", e.line_level, got.line_level);
                errors++;
            end
            if (got.byte_taken !== e.byte_taken) begin
                $error("byte_taken: expected %0d, actual %0d", e.byte_taken, got.byte_taken);
                errors++;
            end
            if (got.busy_res !== e.busy_res) begin
                $error("busy_res: expected %0d, actual %0d", e.busy_res, got.busy_res);
                errors++;
            end
            if (got.underrun !== e.underrun) begin
                $error("underrun: expected %0d, actual %0d", e.underrun, got.underrun);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_byte_valid;
    logic [7:0]                s_byte_value;
    logic                      s_byte_last;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_line_level;
    logic                      m_byte_taken;
    logic                      m_busy_res;
    logic                      m_underrun;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    line_tick_scoreboard sb;
    int sender_idle_pct;
    int recv_stall_pct;
    int rx_hold_cycles;
    int frame_left;

    // bit period, zero high, one high, latch, requests
    int timing_tab [12][5] = '{
        '{1,    1, 1,    0,     75},
        '{2,    1, 2,    1,     75},
        '{3,    1, 2,    3,     75},
        '{4,    1, 3,    2,     75},
        '{5,    0, 7,    10,    75},
        '{2,    5, 0,    0,     75},
        '{1023, 1, 1023, 65535, 60},
        '{3,    2, 1,    65535, 75},
        '{6,    2, 4,    5,     75},
        '{60,   17, 34,  48000, 75},
        '{2,    1, 1,    4,     75},
        '{1,    0, 1023, 3,     75}
    };

    ws2812_pulse_width_serializer_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_valid (s_byte_valid),
        .s_byte_value (s_byte_value),
        .s_byte_last  (s_byte_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_level (m_line_level),
        .m_byte_taken (m_byte_taken),
        .m_busy_res   (m_busy_res),
        .m_underrun   (m_underrun),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("ws2812_pulse_width_serializer_top_tb: errors");
        $finish;
    end

    // result side: sample at the rising edge, drive ready at the falling edge
    initial begin
        result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.line_level = m_line_level;
                got.byte_taken = m_byte_taken;
                got.busy_res   = m_busy_res;
                got.underrun   = m_underrun;
                sb.check_result(got);
            end
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // entered and left at a falling edge; valid is left high for the next request
    task automatic send_tick(input bit bv, input logic [7:0] val, input bit last);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_byte_valid <= bv;
        s_byte_value <= val;
        s_byte_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(bv, val, last);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, data);
        @(negedge aclk);
    endtask

    // unused upper bits of the bit period and high time writes carry noise
    task automatic apply_timing(input int unsigned p, input int unsigned z,
                                input int unsigned o, input int unsigned l);
        logic [CFG_DATA_BITS-1:0] d;
        d = CFG_DATA_BITS'($urandom);
        d[TIME_BITS-1:0] = TIME_BITS'(p);
        write_reg(REG_BIT_PERIOD, d);
        d = CFG_DATA_BITS'($urandom);
        d[TIME_BITS-1:0] = TIME_BITS'(z);
        write_reg(REG_ZERO_HIGH, d);
        d = CFG_DATA_BITS'($urandom);
        d[TIME_BITS-1:0] = TIME_BITS'(o);
        write_reg(REG_ONE_HIGH, d);
        write_reg(REG_LATCH, CFG_DATA_BITS'(l));
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed frames: bytes offered at boundaries, noise while busy
    task automatic offer_next();
        bit         bv;
        bit         lst;
        logic [7:0] val;
        int         r;
        int         pick;
        phase_t     ph;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        val  = 8'($urandom_range(0, 255));
        if (pick == 0) val = 8'h00;
        if (pick == 1) val = 8'hFF;
        ph  = sb.phase_now();
        lst = 1'($urandom_range(0, 1));
        if (ph == PH_GAP) bv = (r < 88);
        else if (ph == PH_IDLE) bv = (r < 55);
        else bv = (r < 30);
        if (bv && (ph == PH_GAP || ph == PH_IDLE)) begin
            if (frame_left == 0) frame_left = $urandom_range(1, 4);
            lst = (frame_left == 1);
            frame_left--;
            if ($urandom_range(0, 99) < 5) lst = ~lst;
        end
        send_tick(bv, val, lst);
    endtask

    initial begin
        int i;
        int k;
        sb              = new();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        rx_hold_cycles  = 0;
        frame_left      = 0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_byte_valid    = 1'b0;
        s_byte_value    = '0;
        s_byte_last     = 1'b0;
        m_ready         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset timing, then a timing change part way through a bit
        send_tick(1, 8'hFF, 0);
        send_tick(0, 8'h00, 0);
        send_tick(1, 8'h00, 1);
        drain();
        // zero period, zero-bit high time of nought, one-bit high past the period, no latch
        apply_timing(0, 0, 1023, 0);
        repeat (8) send_tick(1, 8'hA5, 1);
        send_tick(0, 8'hFF, 1);
        send_tick(0, 8'h00, 0);
        send_tick(1, 8'h00, 1);
        repeat (7) send_tick(0, 8'h00, 0);
        send_tick(1, 8'h80, 1);
        send_tick(1, 8'h01, 0);
        drain();

        for (i = 0; i < 12; i++) begin
            case (i % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            apply_timing(timing_tab[i][0], timing_tab[i][1], timing_tab[i][2],
                         timing_tab[i][3]);
            if (i == 4) rx_hold_cycles = 40;
            for (k = 0; k < timing_tab[i][4]; k++) begin
                if (i == 6 && k == timing_tab[i][4] / 2) drain();
                offer_next();
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("ws2812_pulse_width_serializer_top_tb: clean");
        end else begin
            $display("ws2812_pulse_width_serializer_top_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/wsps_pkg.sv
hw/rtl/wsps_cfg_regs.sv
hw/rtl/wsps_encoder.sv
hw/rtl/ws2812_pulse_width_serializer_top.sv
tb/ws2812_pulse_width_serializer_top_tb.sv
